### hdl/wegs_pkg.sv
// Shared types, constants and fixed-point helpers of the wave grid stepper.
package wegs_pkg;

   localparam int GRID_WIDTH_DEF  = 128;
   localparam int GRID_HEIGHT_DEF = 128;
   localparam int CELL_X_BITS     = 7;
   localparam int CELL_Y_BITS     = 7;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 17;

   localparam logic [15:0] DT_RESET    = 16'd273;
   localparam logic [16:0] DAMP_RESET  = 17'd65536;
   localparam logic [15:0] SPEED_RESET = 16'd7680;

   // boundary mode bits
   localparam int MODE_TOP    = 0;
   localparam int MODE_BOTTOM = 1;
   localparam int MODE_LEFT   = 2;
   localparam int MODE_RIGHT  = 3;

   typedef enum logic [1:0] {
      OP_SET_HEIGHT,
      OP_SET_MEDIUM,
      OP_READ,
      OP_STEP
   } op_type;

   typedef enum logic [1:0] {
      CSR_BOUNDARY,
      CSR_DT,
      CSR_HEIGHT_DAMP,
      CSR_VELOCITY_DAMP
   } csr_index_type;

   // absorbing sides in the order they are applied
   typedef enum logic [1:0] {
      SIDE_BOTTOM,
      SIDE_TOP,
      SIDE_LEFT,
      SIDE_RIGHT
   } side_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_FINISH,
      ST_WALL_RD,
      ST_WALL_WR,
      ST_LAP_C,
      ST_LAP_E,
      ST_LAP_W,
      ST_LAP_N,
      ST_LAP_S,
      ST_LAP_M0,
      ST_LAP_M1,
      ST_LAP_M2,
      ST_LAP_M3,
      ST_LAP_WR,
      ST_ABS_SEL,
      ST_ABS_C,
      ST_ABS_I,
      ST_ABS_M,
      ST_ABS_WR,
      ST_INT_C,
      ST_INT_D,
      ST_INT_U,
      ST_INT_H,
      ST_INT_WR
   } state_type;

   // round(v / 2^sh), ties away from zero
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int unsigned sh);
      logic [63:0] m;
      m = v[63] ? 64'(-v) : 64'(v);
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return v[63] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### hdl/wegs_if.sv
// Request and response channels of the wave grid stepper.
interface wegs_req_if #(
   parameter int X_BITS = wegs_pkg::CELL_X_BITS,
   parameter int Y_BITS = wegs_pkg::CELL_Y_BITS
) ();
   import wegs_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          op;
   logic [X_BITS-1:0]   cell_x;
   logic [Y_BITS-1:0]   cell_y;
   logic signed [31:0]  height_in;
   logic [15:0]         speed_in;
   logic                wall_in;

   modport source(output valid, op, cell_x, cell_y, height_in, speed_in, wall_in,
                  input ready);
   modport sink(input valid, op, cell_x, cell_y, height_in, speed_in, wall_in,
                output ready);
endinterface

interface wegs_rsp_if ();
   import wegs_pkg::*;

   logic               valid;
   logic               ready;
   logic signed [31:0] height_out;
   logic signed [31:0] velocity_out;

   modport source(output valid, height_out, velocity_out, input ready);
   modport sink(input valid, height_out, velocity_out, output ready);
endinterface

### hdl/wave_equation_grid_step.sv
// 2-D wave grid stepper: one cell store holding height, velocity and medium, with a step sequencer.
//
// One item is handled at a time, all through the single read port of the cell store. A step
// makes four passes over the grid: the wall pass over every cell, the Laplacian pass over
// the interior cells, the absorbing pass over the cells next to the border on each absorbing side, and
// the integrate and damp pass over the interior cells. After reset the store is cleared
// one entry per cycle before the first item is taken; register writes are taken
// throughout. A result waits in an output register, so the next item is taken while it
// is still not taken downstream.
module wave_equation_grid_step #(
   parameter int GRID_WIDTH  = wegs_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = wegs_pkg::GRID_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   wegs_req_if.sink                            req_ch,
   wegs_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [wegs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wegs_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import wegs_pkg::*;

   localparam int XW    = $clog2(GRID_WIDTH);
   localparam int YW    = $clog2(GRID_HEIGHT);
   localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = (XW > YW) ? XW : YW;

   localparam logic [AW-1:0] ROW_STEP  = AW'(GRID_WIDTH);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
   localparam logic [AW-1:0] INT_FIRST = AW'(GRID_WIDTH + 1);

   // cell store: {wall, speed, velocity, height}, one write enable per field
   logic [80:0]        cell_mem [CELLS];

   logic signed [31:0] h_rd_ff, v_rd_ff;
   logic [16:0]        m_rd_ff;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic               h_we, v_we, m_we;
   logic signed [31:0] h_wd, v_wd;
   logic [16:0]        m_wd;

   // configuration
   logic [3:0]  bmode_ff, bmode_in;
   logic [15:0] dt_ff, dt_in;
   logic [16:0] hd_ff, hd_in;
   logic [16:0] vd_ff, vd_in;

   // control
   state_type     state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   side_type      side_ff, side_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload
   logic               inside_ff, inside_in;
   logic signed [31:0] res_h_ff, res_h_in, res_v_ff, res_v_in;
   logic signed [31:0] rsp_h_ff, rsp_h_in, rsp_v_ff, rsp_v_in;
   logic signed [31:0] hc_ff, hc_in, vc_ff, vc_in, u_ff, u_in;
   logic [15:0]        s_ff, s_in;
   logic signed [35:0] lap_ff, lap_in;
   logic [34:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [31:0]        ss_ff, ss_in;
   logic [47:0]        sdt_ff, sdt_in;
   logic [32:0]        k_ff, k_in;
   logic [50:0]        plo_ff, plo_in;
   logic [51:0]        phi_ff, phi_in;
   logic signed [49:0] prod_ff, prod_in, pvd_ff, pvd_in, ph_ff, ph_in;

   // request decode
   op_type        req_op;
   logic [XW-1:0] req_x;
   logic [YW-1:0] req_y;
   logic          req_inside;
   logic [AW-1:0] req_addr;

   assign req_op     = op_type'(req_ch.op);
   assign req_x      = XW'(req_ch.cell_x);
   assign req_y      = YW'(req_ch.cell_y);
   assign req_inside = ({1'b0, req_x} < (XW + 1)'(GRID_WIDTH))
                    && ({1'b0, req_y} < (YW + 1)'(GRID_HEIGHT));
   assign req_addr   = AW'(32'(req_y) * GRID_WIDTH + 32'(req_x));

   // interior raster walk
   logic          row_end, int_last;
   logic [XW-1:0] int_x_nx;
   logic [YW-1:0] int_y_nx;
   logic [AW-1:0] int_addr_nx;

   assign row_end     = x_ff == XW'(GRID_WIDTH - 2);
   assign int_last    = row_end && (y_ff == YW'(GRID_HEIGHT - 2));
   assign int_x_nx    = row_end ? XW'(1) : x_ff + XW'(1);
   assign int_y_nx    = row_end ? y_ff + YW'(1) : y_ff;
   assign int_addr_nx = row_end ? addr_ff + AW'(3) : addr_ff + AW'(1);

   // wall pass border test
   logic mid_x, wall_hit;
   assign mid_x    = (x_ff != '0) && (x_ff != XW'(GRID_WIDTH - 1));
   assign wall_hit = m_rd_ff[16]
                  || (!bmode_ff[MODE_TOP] && y_ff == YW'(GRID_HEIGHT - 1) && mid_x)
                  || (!bmode_ff[MODE_BOTTOM] && y_ff == '0 && mid_x)
                  || (!bmode_ff[MODE_LEFT] && x_ff == '0)
                  || (!bmode_ff[MODE_RIGHT] && x_ff == XW'(GRID_WIDTH - 1));

   // absorbing side geometry
   logic          side_en;
   logic [AW-1:0] side_start, side_stride, abs_inner;
   logic [CW-1:0] side_last;

   always_comb begin
      unique case (side_ff)
         SIDE_BOTTOM: begin
            side_en     = bmode_ff[MODE_BOTTOM];
            side_start  = INT_FIRST;
            side_stride = AW'(1);
            side_last   = CW'(GRID_WIDTH - 3);
            abs_inner   = addr_ff + ROW_STEP;
         end
         SIDE_TOP: begin
            side_en     = bmode_ff[MODE_TOP];
            side_start  = AW'((GRID_HEIGHT - 2) * GRID_WIDTH + 1);
            side_stride = AW'(1);
            side_last   = CW'(GRID_WIDTH - 3);
            abs_inner   = addr_ff - ROW_STEP;
         end
         SIDE_LEFT: begin
            side_en     = bmode_ff[MODE_LEFT];
            side_start  = INT_FIRST;
            side_stride = ROW_STEP;
            side_last   = CW'(GRID_HEIGHT - 3);
            abs_inner   = addr_ff + AW'(1);
         end
         SIDE_RIGHT: begin
            side_en     = bmode_ff[MODE_RIGHT];
            side_start  = AW'(2 * GRID_WIDTH - 2);
            side_stride = ROW_STEP;
            side_last   = CW'(GRID_HEIGHT - 3);
            abs_inner   = addr_ff - AW'(1);
         end
      endcase
   end

   // datapath terms
   logic [51:0]        plo_rnd;
   logic [52:0]        lap_r;
   logic signed [63:0] vsum;
   logic signed [32:0] abs_diff;

   assign plo_rnd  = ({1'b0, plo_ff} + 52'h8000) >> 16;
   assign lap_r    = 53'(phi_ff) + 53'(plo_rnd);
   assign vsum     = 64'(vc_ff) + (neg_ff ? -64'(lap_r) : 64'(lap_r));
   assign abs_diff = 33'(h_rd_ff) - 33'(hc_ff);

   // configuration writes
   always_comb begin
      bmode_in = bmode_ff;
      dt_in    = dt_ff;
      hd_in    = hd_ff;
      vd_in    = vd_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BOUNDARY:      bmode_in = csr_wdata[3:0];
            CSR_DT:            dt_in    = csr_wdata[15:0];
            CSR_HEIGHT_DAMP:   hd_in    = csr_wdata;
            CSR_VELOCITY_DAMP: vd_in    = csr_wdata;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      cnt_in       = cnt_ff;
      side_in      = side_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_h_in     = rsp_h_ff;
      rsp_v_in     = rsp_v_ff;
      inside_in    = inside_ff;
      res_h_in     = res_h_ff;
      res_v_in     = res_v_ff;
      hc_in        = hc_ff;
      vc_in        = vc_ff;
      u_in         = u_ff;
      s_in         = s_ff;
      lap_in       = lap_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      ss_in        = ss_ff;
      sdt_in       = sdt_ff;
      k_in         = k_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      prod_in      = prod_ff;
      pvd_in       = pvd_ff;
      ph_in        = ph_ff;
      rd_addr      = addr_ff;
      wr_addr      = addr_ff;
      h_we         = 1'b0;
      v_we         = 1'b0;
      m_we         = 1'b0;
      h_wd         = '0;
      v_wd         = '0;
      m_wd         = '0;
      req_ch.ready = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            h_we = 1'b1;
            v_we = 1'b1;
            m_we = 1'b1;
            m_wd = {1'b0, SPEED_RESET};
            if (addr_ff == LAST_CELL) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            rd_addr      = req_addr;
            if (req_ch.valid) begin
               res_h_in  = '0;
               res_v_in  = '0;
               inside_in = req_inside;
               unique case (req_op)
                  OP_SET_HEIGHT: begin
                     h_we     = req_inside;
                     wr_addr  = req_addr;
                     h_wd     = req_ch.height_in;
                     state_in = ST_FINISH;
                  end
                  OP_SET_MEDIUM: begin
                     m_we     = req_inside;
                     wr_addr  = req_addr;
                     m_wd     = {req_ch.wall_in, req_ch.speed_in};
                     state_in = ST_FINISH;
                  end
                  OP_READ: state_in = ST_READ;
                  OP_STEP: begin
                     addr_in  = '0;
                     x_in     = '0;
                     y_in     = '0;
                     state_in = ST_WALL_RD;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (inside_ff) begin
               res_h_in = h_rd_ff;
               res_v_in = v_rd_ff;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_h_in     = res_h_ff;
               rsp_v_in     = res_v_ff;
               state_in     = ST_IDLE;
            end
         end
         // pass 1: walls and reflecting borders
         ST_WALL_RD: state_in = ST_WALL_WR;
         ST_WALL_WR: begin
            h_we = wall_hit;
            v_we = wall_hit;
            if (addr_ff == LAST_CELL) begin
               x_in     = XW'(1);
               y_in     = YW'(1);
               addr_in  = INT_FIRST;
               state_in = ST_LAP_C;
            end else begin
               addr_in = addr_ff + AW'(1);
               if (x_ff == XW'(GRID_WIDTH - 1)) begin
                  x_in = '0;
                  y_in = y_ff + YW'(1);
               end else begin
                  x_in = x_ff + XW'(1);
               end
               state_in = ST_WALL_RD;
            end
         end
         // pass 2: velocity from the Laplacian
         ST_LAP_C: state_in = ST_LAP_E;
         ST_LAP_E: begin
            vc_in    = v_rd_ff;
            s_in     = m_rd_ff[15:0];
            lap_in   = 36'sd0 - (36'(h_rd_ff) <<< 2);
            rd_addr  = addr_ff + AW'(1);
            state_in = ST_LAP_W;
         end
         ST_LAP_W: begin
            lap_in   = lap_ff + 36'(h_rd_ff);
            ss_in    = s_ff * s_ff;
            rd_addr  = addr_ff - AW'(1);
            state_in = ST_LAP_N;
         end
         ST_LAP_N: begin
            lap_in   = lap_ff + 36'(h_rd_ff);
            sdt_in   = ss_ff * dt_ff;
            rd_addr  = addr_ff + ROW_STEP;
            state_in = ST_LAP_S;
         end
         ST_LAP_S: begin
            lap_in   = lap_ff + 36'(h_rd_ff);
            k_in     = 33'(({1'b0, sdt_ff} + 49'h8000) >> 16);
            rd_addr  = addr_ff - ROW_STEP;
            state_in = ST_LAP_M0;
         end
         ST_LAP_M0: begin
            lap_in   = lap_ff + 36'(h_rd_ff);
            state_in = ST_LAP_M1;
         end
         ST_LAP_M1: begin
            neg_in   = lap_ff[35];
            mag_in   = lap_ff[35] ? 35'(-lap_ff) : 35'(lap_ff);
            state_in = ST_LAP_M2;
         end
         ST_LAP_M2: begin
            plo_in   = mag_ff * k_ff[15:0];
            state_in = ST_LAP_M3;
         end
         ST_LAP_M3: begin
            phi_in   = mag_ff * k_ff[32:16];
            state_in = ST_LAP_WR;
         end
         ST_LAP_WR: begin
            v_we = 1'b1;
            v_wd = sat32(vsum);
            if (int_last) begin
               side_in  = SIDE_BOTTOM;
               state_in = ST_ABS_SEL;
            end else begin
               x_in     = int_x_nx;
               y_in     = int_y_nx;
               addr_in  = int_addr_nx;
               state_in = ST_LAP_C;
            end
         end
         // pass 3: absorbing edges, later sides overwrite earlier ones
         ST_ABS_SEL: begin
            if (side_en) begin
               addr_in  = side_start;
               cnt_in   = '0;
               state_in = ST_ABS_C;
            end else if (side_ff == SIDE_RIGHT) begin
               x_in     = XW'(1);
               y_in     = YW'(1);
               addr_in  = INT_FIRST;
               state_in = ST_INT_C;
            end else begin
               side_in = side_type'(side_ff + 2'd1);
            end
         end
         ST_ABS_C: state_in = ST_ABS_I;
         ST_ABS_I: begin
            hc_in    = h_rd_ff;
            s_in     = m_rd_ff[15:0];
            rd_addr  = abs_inner;
            state_in = ST_ABS_M;
         end
         ST_ABS_M: begin
            prod_in  = abs_diff * $signed({1'b0, s_ff});
            state_in = ST_ABS_WR;
         end
         ST_ABS_WR: begin
            v_we = 1'b1;
            v_wd = sat32(round_shift(64'(prod_ff), 8));
            if (cnt_ff == side_last) begin
               if (side_ff == SIDE_RIGHT) begin
                  x_in     = XW'(1);
                  y_in     = YW'(1);
                  addr_in  = INT_FIRST;
                  state_in = ST_INT_C;
               end else begin
                  side_in  = side_type'(side_ff + 2'd1);
                  state_in = ST_ABS_SEL;
               end
            end else begin
               cnt_in   = cnt_ff + CW'(1);
               addr_in  = addr_ff + side_stride;
               state_in = ST_ABS_C;
            end
         end
         // pass 4: integrate height, then damp, in the same sweep
         ST_INT_C: state_in = ST_INT_D;
         ST_INT_D: begin
            hc_in    = h_rd_ff;
            vc_in    = v_rd_ff;
            prod_in  = v_rd_ff * $signed({1'b0, dt_ff});
            state_in = ST_INT_U;
         end
         ST_INT_U: begin
            u_in     = sat32(64'(hc_ff) + round_shift(64'(prod_ff), 16));
            pvd_in   = vc_ff * $signed({1'b0, vd_ff});
            state_in = ST_INT_H;
         end
         ST_INT_H: begin
            ph_in    = u_ff * $signed({1'b0, hd_ff});
            state_in = ST_INT_WR;
         end
         ST_INT_WR: begin
            h_we = 1'b1;
            v_we = 1'b1;
            h_wd = sat32(round_shift(64'(ph_ff), 16));
            v_wd = sat32(round_shift(64'(pvd_ff), 16));
            if (int_last) begin
               state_in = ST_FINISH;
            end else begin
               x_in     = int_x_nx;
               y_in     = int_y_nx;
               addr_in  = int_addr_nx;
               state_in = ST_INT_C;
            end
         end
      endcase
   end

   // cell store, read data registered
   always_ff @(posedge clock) begin
      if (h_we) cell_mem[wr_addr][31:0]  <= h_wd;
      if (v_we) cell_mem[wr_addr][63:32] <= v_wd;
      if (m_we) cell_mem[wr_addr][80:64] <= m_wd;
      {m_rd_ff, v_rd_ff, h_rd_ff} <= cell_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         side_ff      <= SIDE_BOTTOM;
         rsp_valid_ff <= 1'b0;
         bmode_ff     <= '0;
         dt_ff        <= DT_RESET;
         hd_ff        <= DAMP_RESET;
         vd_ff        <= DAMP_RESET;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         side_ff      <= side_in;
         rsp_valid_ff <= rsp_valid_in;
         bmode_ff     <= bmode_in;
         dt_ff        <= dt_in;
         hd_ff        <= hd_in;
         vd_ff        <= vd_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      cnt_ff    <= cnt_in;
      inside_ff <= inside_in;
      res_h_ff  <= res_h_in;
      res_v_ff  <= res_v_in;
      rsp_h_ff  <= rsp_h_in;
      rsp_v_ff  <= rsp_v_in;
      hc_ff     <= hc_in;
      vc_ff     <= vc_in;
      u_ff      <= u_in;
      s_ff      <= s_in;
      lap_ff    <= lap_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      ss_ff     <= ss_in;
      sdt_ff    <= sdt_in;
      k_ff      <= k_in;
      plo_ff    <= plo_in;
      phi_ff    <= phi_in;
      prod_ff   <= prod_in;
      pvd_ff    <= pvd_in;
      ph_ff     <= ph_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.height_out   = rsp_h_ff;
   assign rsp_ch.velocity_out = rsp_v_ff;

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      (h_we || v_we || m_we) |-> wr_addr <= LAST_CELL)
      else $error("store write beyond last cell");

   a_no_write_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH || state_ff == ST_READ) |-> !(h_we || v_we || m_we))
      else $error("store written while a result is pending");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result loaded outside finish");

   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAP_WR || state_ff == ST_INT_WR)
      |-> (x_ff != '0 && y_ff != '0
           && x_ff != XW'(GRID_WIDTH - 1) && y_ff != YW'(GRID_HEIGHT - 1)))
      else $error("interior pass touched a border cell");

endmodule

### dv/wave_equation_grid_step_checker.sv
// Checker for the wave grid stepper: tracks the grid, predicts every response and compares.
module wave_equation_grid_step_checker (
   input  logic                                clock,
   input  logic                                reset,
   wegs_req_if                                 req_mon,
   wegs_rsp_if                                 rsp_mon,
   input  logic                                csr_we,
   input  logic [wegs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wegs_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                  fail_count,
   output int                                  pending
);
   import wegs_pkg::*;

   localparam int W = GRID_WIDTH_DEF;
   localparam int H = GRID_HEIGHT_DEF;
   localparam int CELLS = W * H;

   typedef struct packed {
      logic signed [31:0] height;
      logic signed [31:0] velocity;
   } cell_read_type;

   logic signed [31:0] height_map [CELLS];
   logic signed [31:0] velocity_map [CELLS];
   logic [15:0]        speed_map [CELLS];
   logic               wall_map [CELLS];

   logic [3:0]  sides;
   logic [15:0] dt;
   logic [16:0] height_scale;
   logic [16:0] velocity_scale;

   cell_read_type expected_reads [$];

   // divide by 2^sh, ties away from zero
   function automatic longint div_round(input longint v, input int sh);
      longint unsigned m;
      m = (v < 0) ? longint'(-v) : longint'(v);
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // a * b / 2^16 with b split so the product stays within 64 bits
   function automatic longint scale_frac(input longint a, input longint unsigned b);
      longint unsigned m;
      longint unsigned r;
      m = (a < 0) ? longint'(-a) : longint'(a);
      r = m * (b >> 16) + ((m * (b & 64'hFFFF) + 64'h8000) >> 16);
      return (a < 0) ? -longint'(r) : longint'(r);
   endfunction

   function automatic void absorb_cell(input int c, input int inner);
      longint diff;
      diff = longint'(height_map[inner]) - longint'(height_map[c]);
      velocity_map[c] = clamp32(div_round(diff * longint'(speed_map[c]), 8));
   endfunction

   function automatic void advance_grid();
      int i;
      bit mid_x;
      bit blocked;
      longint unsigned s;
      longint unsigned k;
      longint lap;
      longint u;
      for (int y = 0; y < H; y++) begin
         for (int x = 0; x < W; x++) begin
            i = y * W + x;
            mid_x = (x >= 1) && (x <= W - 2);
            blocked = wall_map[i];
            if (!sides[MODE_TOP] && y == H - 1 && mid_x) blocked = 1'b1;
            if (!sides[MODE_BOTTOM] && y == 0 && mid_x) blocked = 1'b1;
            if (!sides[MODE_LEFT] && x == 0) blocked = 1'b1;
            if (!sides[MODE_RIGHT] && x == W - 1) blocked = 1'b1;
            if (blocked) begin
               height_map[i] = '0;
               velocity_map[i] = '0;
            end
         end
      end
      for (int y = 1; y < H - 1; y++) begin
         for (int x = 1; x < W - 1; x++) begin
            i = y * W + x;
            s = speed_map[i];
            k = (s * s * longint'(dt) + 64'h8000) >> 16;
            lap = longint'(height_map[i + 1]) + longint'(height_map[i - 1])
                + longint'(height_map[i + W]) + longint'(height_map[i - W])
                - 4 * longint'(height_map[i]);
            velocity_map[i] = clamp32(longint'(velocity_map[i]) + scale_frac(lap, k));
         end
      end
      // edge sides run bottom, top, left, right; later sides win at corners
      if (sides[MODE_BOTTOM])
         for (int x = 1; x < W - 1; x++) absorb_cell(W + x, 2 * W + x);
      if (sides[MODE_TOP])
         for (int x = 1; x < W - 1; x++) absorb_cell((H - 2) * W + x, (H - 3) * W + x);
      if (sides[MODE_LEFT])
         for (int y = 1; y < H - 1; y++) absorb_cell(y * W + 1, y * W + 2);
      if (sides[MODE_RIGHT])
         for (int y = 1; y < H - 1; y++) absorb_cell(y * W + W - 2, y * W + W - 3);
      for (int y = 1; y < H - 1; y++) begin
         for (int x = 1; x < W - 1; x++) begin
            i = y * W + x;
            u = longint'(height_map[i])
              + div_round(longint'(velocity_map[i]) * longint'(dt), 16);
            u = clamp32(u);
            height_map[i] = clamp32(div_round(u * longint'(height_scale), 16));
            velocity_map[i] = clamp32(div_round(longint'(velocity_map[i])
                                                * longint'(velocity_scale), 16));
         end
      end
   endfunction

   assign pending = expected_reads.size();

   always @(posedge clock) begin
      cell_read_type got;
      cell_read_type want;
      int idx;
      int errs;
      errs = 0;
      if (reset) begin
         for (int i = 0; i < CELLS; i++) begin
            height_map[i] = '0;
            velocity_map[i] = '0;
            speed_map[i] = SPEED_RESET;
            wall_map[i] = 1'b0;
         end
         sides = '0;
         dt = DT_RESET;
         height_scale = DAMP_RESET;
         velocity_scale = DAMP_RESET;
         expected_reads.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_BOUNDARY:      sides = csr_wdata[3:0];
               CSR_DT:            dt = csr_wdata[15:0];
               CSR_HEIGHT_DAMP:   height_scale = csr_wdata;
               CSR_VELOCITY_DAMP: velocity_scale = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.height = rsp_mon.height_out;
            got.velocity = rsp_mon.velocity_out;
            if (expected_reads.size() == 0) begin
               $error("response with nothing outstanding: height %0d velocity %0d",
                      got.height, got.velocity);
               errs++;
            end else begin
               want = expected_reads.pop_front();
               if (got.height !== want.height) begin
                  $error("height_out: expected %0d, actual %0d", want.height, got.height);
                  errs++;
               end
               if (got.velocity !== want.velocity) begin
                  $error("velocity_out: expected %0d, actual %0d",
                         want.velocity, got.velocity);
                  errs++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            idx = int'(req_mon.cell_y) * W + int'(req_mon.cell_x);
            want = '0;
            case (op_type'(req_mon.op))
               OP_SET_HEIGHT: height_map[idx] = req_mon.height_in;
               OP_SET_MEDIUM: begin
                  speed_map[idx] = req_mon.speed_in;
                  wall_map[idx] = req_mon.wall_in;
               end
               OP_READ: begin
                  want.height = height_map[idx];
                  want.velocity = velocity_map[idx];
               end
               default: advance_grid();
            endcase
            expected_reads = {expected_reads, want};
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

### dv/wave_equation_grid_step_tb.sv
// Testbench top of the wave grid stepper: stimulus, register phases and verdict.
module wave_equation_grid_step_tb;
   import wegs_pkg::*;

   localparam int STALL_LIMIT = 1_000_000;
   localparam int LONG_HOLD = 400;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;
   int fail_count;
   int pending;
   bit no_gaps;
   int idle_cycles;

   wegs_req_if req_ch ();
   wegs_rsp_if rsp_ch ();

   wave_equation_grid_step DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   wave_equation_grid_step_checker checker_inst (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic send_item(input op_type op, input int x, input int y,
                            input logic [31:0] h, input logic [15:0] s, input logic w);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.op <= op;
      req_ch.cell_x <= x[6:0];
      req_ch.cell_y <= y[6:0];
      req_ch.height_in <= h;
      req_ch.speed_in <= s;
      req_ch.wall_in <= w;
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [16:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // random cell, mostly inside a small patch so reads see the wave
   task automatic pick_cell(output int x, output int y);
      if ($urandom_range(0, 3) == 0) begin
         x = $urandom_range(0, 127);
         y = $urandom_range(0, 127);
      end else begin
         x = $urandom_range(60, 67);
         y = $urandom_range(60, 67);
      end
   endtask

   task automatic random_items(input int count);
      int x;
      int y;
      int pick;
      for (int n = 0; n < count; n++) begin
         no_gaps = (n >= count / 3) && (n < count / 3 + 12);
         pick_cell(x, y);
         pick = $urandom_range(0, 9);
         if (n == count / 2)
            send_item(OP_STEP, x, y, $urandom, 16'($urandom), 1'($urandom_range(0, 1)));
         else if (pick < 3)
            send_item(OP_SET_HEIGHT, x, y, $urandom, 16'($urandom),
                      1'($urandom_range(0, 1)));
         else if (pick < 5)
            send_item(OP_SET_MEDIUM, x, y, $urandom, 16'($urandom),
                      $urandom_range(0, 4) == 0);
         else
            send_item(OP_READ, x, y, $urandom, 16'($urandom), 1'($urandom_range(0, 1)));
      end
      no_gaps = 1'b0;
   endtask

   // response side: random hold-offs, plus one long hold so the input backs up
   initial begin
      int hold;
      int taken;
      taken = 0;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         hold = no_gaps ? 0 : $urandom_range(0, 18);
         if (taken == 30) hold = LONG_HOLD;
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         taken++;
      end
   end

   initial begin
      idle_cycles = 0;
      @(negedge reset);
      do begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end while (idle_cycles < STALL_LIMIT);
      $display("FAIL wave_equation_grid_step");
      $finish;
   end

   initial begin
      no_gaps = 1'b0;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.op <= OP_READ;
      req_ch.cell_x <= '0;
      req_ch.cell_y <= '0;
      req_ch.height_in <= '0;
      req_ch.speed_in <= '0;
      req_ch.wall_in <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: reset registers, all borders reflecting
      send_item(OP_SET_HEIGHT, 64, 64, 32'h7FFF_FFFF, 16'h0, 1'b0);
      send_item(OP_SET_HEIGHT, 65, 64, 32'h8000_0000, 16'hFFFF, 1'b1);
      send_item(OP_SET_HEIGHT, 0, 0, 32'h0001_0000, 16'h0, 1'b0);
      send_item(OP_SET_HEIGHT, 127, 127, 32'hFFFF_FFFF, 16'h0, 1'b0);
      send_item(OP_SET_HEIGHT, 1, 126, 32'h0100_0000, 16'h0, 1'b0);
      send_item(OP_SET_MEDIUM, 64, 65, 32'h0, 16'hFFFF, 1'b0);
      send_item(OP_SET_MEDIUM, 63, 64, 32'h0, 16'h0000, 1'b0);
      send_item(OP_SET_MEDIUM, 66, 64, 32'h1234, 16'h1E00, 1'b1);
      send_item(OP_SET_HEIGHT, 66, 64, 32'h0002_0000, 16'h0, 1'b0);
      send_item(OP_READ, 64, 64, 32'h0, 16'h0, 1'b0);
      send_item(OP_READ, 0, 0, 32'h0, 16'h0, 1'b0);
      send_item(OP_STEP, 0, 0, 32'h0, 16'h0, 1'b0);
      send_item(OP_READ, 64, 64, 32'h0, 16'h0, 1'b0);
      send_item(OP_READ, 65, 64, 32'h0, 16'h0, 1'b0);
      send_item(OP_READ, 64, 65, 32'h0, 16'h0, 1'b0);
      send_item(OP_READ, 66, 64, 32'h0, 16'h0, 1'b0);
      send_item(OP_READ, 0, 0, 32'h0, 16'h0, 1'b0);
      send_item(OP_READ, 127, 127, 32'h0, 16'h0, 1'b0);
      send_item(OP_READ, 1, 126, 32'h0, 16'h0, 1'b0);
      settle();

      // all sides absorbing, longest step, amplifying height, velocity cleared
      write_reg(CSR_BOUNDARY, 17'hF);
      write_reg(CSR_DT, 17'hFFFF);
      write_reg(CSR_HEIGHT_DAMP, 17'h1FFFF);
      write_reg(CSR_VELOCITY_DAMP, 17'h0);
      csr_we <= 1'b0;
      random_items(40);
      settle();

      write_reg(CSR_BOUNDARY, 17'($urandom_range(1, 14)));
      write_reg(CSR_DT, 17'd1);
      write_reg(CSR_HEIGHT_DAMP, 17'($urandom_range(0, 65536)));
      write_reg(CSR_VELOCITY_DAMP, 17'd65536);
      csr_we <= 1'b0;
      random_items(60);
      settle();

      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("PASS wave_equation_grid_step");
      else
         $display("FAIL wave_equation_grid_step");
      $finish;
   end

endmodule

### filelist.f
hdl/wegs_pkg.sv
hdl/wegs_if.sv
hdl/wave_equation_grid_step.sv
dv/wave_equation_grid_step_checker.sv
dv/wave_equation_grid_step_tb.sv
